[rtl/lra_pkg.sv]
// ============================================================================
// lra_pkg
// Shared widths, constants and controller/datapath interface types for the
// largest-remainder apportionment block.
// ============================================================================
`default_nettype none

package lra_pkg;

    localparam int FREQ_W     = 23;
    localparam int COUNT_W    = 12;
    localparam int LETTER_W   = 5;
    localparam int HUNDRED    = 100;
    localparam int HUNDRED_W  = 7;
    localparam int APB_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // register index, taken from the word address
    localparam logic [0:0] REG_TOTAL = 1'b0;

    typedef struct packed {
        logic load;
        logic idx_clr;
        logic idx_inc;
        logic sum_clr;
        logic mul;
        logic div_start;
        logic res_wr;
        logic scan_rd;
        logic update;
        logic out_rd;
    } cmd_t;

    typedef struct packed {
        logic idx_last;
        logic sum_lt_total;
    } status_t;

endpackage

`default_nettype wire

[rtl/largest_remainder_apportion.sv]
// ============================================================================
// largest_remainder_apportion
// Splits a configured total among LETTERS letters by the largest-remainder
// method from per-letter Q(FRAC_BITS) percentage frequencies.
// ============================================================================
// Frequencies enter one item per cycle while busy is low, letter 0 first.
// The item for the last letter starts the apportionment and raises busy:
// each letter then passes through read, multiply, reciprocal divide by the
// 100% constant and write in the shared datapath, after which the remainder
// search runs at most LETTERS + 1 passes over the result memory, and the
// LETTERS counts follow one per cycle on strobe, with last set on the final
// one. The receiver cannot stall: each count is valid for exactly one cycle.
// total_count is read during the apportionment and must be written while
// busy is low.
`default_nettype none

module largest_remainder_apportion import lra_pkg::*; #(
    parameter int LETTERS   = 26,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [FREQ_W-1:0]     freq,
    output logic                       strobe,
    output logic      [LETTER_W-1:0]   letter,
    output logic      [COUNT_W-1:0]    count,
    output logic                       last,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic [COUNT_W-1:0] total_count_reg;
    logic [0:0]         reg_index;
    cmd_t               cmd;
    status_t            status;

    assign reg_index = paddr[CFG_ADDR_W-1:2];
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_count_reg <= '0;
        end
        else if (psel && penable && pwrite && (reg_index == REG_TOTAL))
        begin
            total_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_TOTAL: prdata = APB_DATA_W'(total_count_reg);
            default:   prdata = '0;
        endcase
    end

    lra_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    lra_datapath #(
        .LETTERS   (LETTERS),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .freq        (freq),
        .total_count (total_count_reg),
        .strobe      (strobe),
        .letter      (letter),
        .count       (count),
        .last        (last)
    );

endmodule

`default_nettype wire

[rtl/lra_ram.sv]
// ============================================================================
// lra_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module lra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/lra_ctrl.sv]
// ============================================================================
// lra_ctrl
// Sequencer: loads frequencies, walks the datapath through the per-letter
// divide, the remainder scans and the result readout.
// ============================================================================
`default_nettype none

module lra_ctrl import lra_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire status_t status,
    output logic         busy,
    output cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_RD,
        S_MUL,
        S_DIVI,
        S_DIV,
        S_ITER,
        S_SCAN,
        S_SCAN_END,
        S_UPD,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_LOAD:
            begin
                if (start && !busy_reg)
                begin
                    cmd.load = 1'b1;
                    if (status.idx_last)
                    begin
                        cmd.idx_clr = 1'b1;
                        cmd.sum_clr = 1'b1;
                        state_next  = S_RD;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIVI;
            end
            S_DIVI:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.res_wr = 1'b1;
                if (status.idx_last)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_ITER;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_RD;
                end
            end
            S_ITER:
            begin
                state_next = status.sum_lt_total ? S_SCAN : S_OUT;
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (status.idx_last)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_SCAN_END;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_SCAN_END:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_ITER;
            end
            S_OUT:
            begin
                cmd.out_rd = 1'b1;
                if (status.idx_last)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_LOAD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
        busy_next = (state_next != S_LOAD);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

[rtl/lra_datapath.sv]
// ============================================================================
// lra_datapath
// Frequency and result stores, multiplier, reciprocal divide by the 100%
// constant, running count sum, largest-remainder search and result output.
// ============================================================================
`default_nettype none

module lra_datapath import lra_pkg::*; #(
    parameter int LETTERS   = 26,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cmd_t                cmd,
    output status_t                  status,
    input  wire logic [FREQ_W-1:0]   freq,
    input  wire logic [COUNT_W-1:0]  total_count,
    output logic                     strobe,
    output logic      [LETTER_W-1:0] letter,
    output logic      [COUNT_W-1:0]  count,
    output logic                     last
);

    localparam int IDX_W   = $clog2(LETTERS);
    localparam int PROD_W  = FREQ_W + COUNT_W;
    localparam int HI_W    = PROD_W - FRAC_BITS;
    localparam int RSH     = HI_W + HUNDRED_W;
    localparam int RCP_W   = HI_W + 1;
    localparam int RPROD_W = HI_W + RCP_W;
    localparam int QUO_W   = RPROD_W - RSH;
    localparam int REM_W   = FRAC_BITS + HUNDRED_W;
    localparam int QX_W    = (QUO_W > COUNT_W) ? QUO_W : COUNT_W;
    localparam int SUM_W   = COUNT_W + $clog2(LETTERS);
    localparam int RES_W   = COUNT_W + REM_W;

    // ceil(2^RSH / 100): exact floor division by 100 for any HI_W-bit value
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((64'd1 << RSH) + 64'(HUNDRED - 1)) / 64'(HUNDRED));

    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_d_reg;
    logic               cmp_valid_reg;
    logic               out_valid_reg;

    logic [FREQ_W-1:0]  freq_rdata;
    logic [RES_W-1:0]   res_rdata;
    logic [COUNT_W-1:0] rd_count;
    logic [REM_W-1:0]   rd_rem;

    logic [PROD_W-1:0]    prod_reg;
    logic [HI_W-1:0]      hi;
    logic [RPROD_W-1:0]   rprod;
    logic [QUO_W-1:0]     quo_reg;
    logic [HI_W-1:0]      quo_x100;
    logic [HUNDRED_W-1:0] rem_hi;
    logic [REM_W-1:0]     rem_val;
    logic [QX_W-1:0]      quo_ext;
    logic [COUNT_W-1:0]   count_sat;

    logic [SUM_W-1:0]   sum_reg;

    logic [IDX_W-1:0]   best_idx_reg;
    logic [REM_W-1:0]   best_rem_reg;
    logic [COUNT_W-1:0] best_cnt_reg;
    logic               best_zero;
    logic [COUNT_W-1:0] upd_add;
    logic [COUNT_W:0]   upd_sum;
    logic [COUNT_W-1:0] upd_cnt;

    logic               res_we;
    logic [IDX_W-1:0]   res_waddr;
    logic [RES_W-1:0]   res_wdata;

    assign rd_count = res_rdata[RES_W-1 -: COUNT_W];
    assign rd_rem   = res_rdata[REM_W-1:0];

    assign hi       = prod_reg[PROD_W-1:FRAC_BITS];
    assign rprod    = RPROD_W'(hi) * RPROD_W'(RECIP);
    assign quo_x100 = HI_W'(quo_reg) * HI_W'(HUNDRED);
    assign rem_hi   = HUNDRED_W'(hi - quo_x100);
    assign rem_val  = {rem_hi, prod_reg[FRAC_BITS-1:0]};

    assign quo_ext   = QX_W'(quo_reg);
    assign count_sat = (quo_ext > QX_W'(COUNT_MAX)) ? COUNT_MAX : quo_ext[COUNT_W-1:0];

    assign best_zero = (best_rem_reg == '0);
    assign upd_add   = best_zero ? COUNT_W'(SUM_W'(total_count) - sum_reg) : COUNT_W'(1);
    assign upd_sum   = {1'b0, best_cnt_reg} + {1'b0, upd_add};
    assign upd_cnt   = upd_sum[COUNT_W] ? COUNT_MAX : upd_sum[COUNT_W-1:0];

    assign res_we    = cmd.res_wr | cmd.update;
    assign res_waddr = cmd.update ? best_idx_reg : idx_reg;
    assign res_wdata = cmd.update ? {upd_cnt, REM_W'(0)} : {count_sat, rem_val};

    lra_ram #(
        .WIDTH (FREQ_W),
        .DEPTH (LETTERS)
    ) u_freq_ram (
        .clk   (clk),
        .we    (cmd.load),
        .waddr (idx_reg),
        .wdata (freq),
        .raddr (idx_reg),
        .rdata (freq_rdata)
    );

    lra_ram #(
        .WIDTH (RES_W),
        .DEPTH (LETTERS)
    ) u_res_ram (
        .clk   (clk),
        .we    (res_we),
        .waddr (res_waddr),
        .wdata (res_wdata),
        .raddr (idx_reg),
        .rdata (res_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            idx_d_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
        end
        else
        begin
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            idx_d_reg     <= idx_reg;
            cmp_valid_reg <= cmd.scan_rd;
            out_valid_reg <= cmd.out_rd;

            if (cmd.sum_clr)
            begin
                sum_reg <= '0;
            end
            else if (cmd.res_wr)
            begin
                sum_reg <= sum_reg + SUM_W'(count_sat);
            end
            else if (cmd.update)
            begin
                sum_reg <= best_zero ? SUM_W'(total_count) : sum_reg + SUM_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(freq_rdata) * PROD_W'(total_count);
        end

        if (cmd.div_start)
        begin
            quo_reg <= rprod[RPROD_W-1:RSH];
        end

        if (cmp_valid_reg && ((idx_d_reg == '0) || (rd_rem > best_rem_reg)))
        begin
            best_idx_reg <= idx_d_reg;
            best_rem_reg <= rd_rem;
            best_cnt_reg <= rd_count;
        end
    end

    assign status.idx_last     = (idx_reg == IDX_W'(LETTERS - 1));
    assign status.sum_lt_total = (sum_reg < SUM_W'(total_count));

    assign strobe = out_valid_reg;
    assign letter = LETTER_W'(idx_d_reg);
    assign count  = rd_count;
    assign last   = out_valid_reg && (idx_d_reg == IDX_W'(LETTERS - 1));

endmodule

`default_nettype wire

[tb/tb_largest_remainder_apportion.sv]
// ============================================================================
// tb_largest_remainder_apportion
// Self-checking testbench for the largest-remainder apportionment block.
// Frames of 26 letter frequencies are loaded item by item over the start/busy
// handshake. total_count is set over the APB port and read back. The 26
// letter counts of each frame are checked against expected counts from the frame
// table or an internal apportionment predictor. The directed frames come first,
// then random frames; random gaps separate the items of both.
// ============================================================================
`timescale 1ns / 100ps

module tb_largest_remainder_apportion;
    import lra_pkg::*;

    localparam int LETTERS   = 26;
    localparam int FRAC_BITS = 16;
    localparam int NO_WRITE  = -1;
    localparam int RANDOM_FRAMES = 5;
    localparam longint unsigned FULL_SCALE = 64'(HUNDRED) << FRAC_BITS;
    localparam logic [CFG_ADDR_W-1:0] TOTAL_ADDR = CFG_ADDR_W'({REG_TOTAL, 2'b00});
    localparam logic [FREQ_W-1:0] FREQ_ONES = '1;

    typedef enum {PAT_ALT_BITS, PAT_ZERO, PAT_MAX, PAT_UNIFORM, PAT_OVER} pattern_e;
    typedef enum {MIX_WELL, MIX_SPARSE, MIX_NOISE} mix_e;

    typedef struct {
        int       total;
        int       mid_total;
        pattern_e pattern;
        bit       typed;
        int       exp_first;
        int       exp_rest;
    } frame_row_t;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } letter_count_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [FREQ_W-1:0]     freq;
    logic                  strobe;
    logic [LETTER_W-1:0]   letter;
    logic [COUNT_W-1:0]    count;
    logic                  last;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic [FREQ_W-1:0]  freq_mem [LETTERS];
    int                 next_letter;
    logic [COUNT_W-1:0] total_model;
    letter_count_t      pending_counts [$];
    int                 mismatches;

    frame_row_t frame_table [6] = '{
        '{NO_WRITE, NO_WRITE, PAT_ALT_BITS, 1'b1, 0,    0},
        '{4095,     NO_WRITE, PAT_ZERO,     1'b1, 4095, 0},
        '{4095,     NO_WRITE, PAT_MAX,      1'b1, 4095, 4095},
        '{0,        NO_WRITE, PAT_MAX,      1'b1, 0,    0},
        '{1000,     7,        PAT_UNIFORM,  1'b0, 0,    0},
        '{37,       NO_WRITE, PAT_OVER,     1'b0, 0,    0}
    };

    largest_remainder_apportion #(
        .LETTERS   (LETTERS),
        .FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .freq    (freq),
        .strobe  (strobe),
        .letter  (letter),
        .count   (count),
        .last    (last),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report(input string msg);
        $display("ERROR: %s", msg);
        mismatches++;
    endtask

    // apportion the stored frame and queue the 26 expected counts
    function automatic void predict_counts();
        longint unsigned    prod;
        longint unsigned    quot;
        longint unsigned    rem [LETTERS];
        logic [COUNT_W-1:0] cnt [LETTERS];
        int                 sum;
        int                 best;

        sum = 0;
        for (int i = 0; i < LETTERS; i++)
        begin
            prod   = 64'(freq_mem[i]) * 64'(total_model);
            quot   = prod / FULL_SCALE;
            rem[i] = prod % FULL_SCALE;
            cnt[i] = (quot > 64'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(quot);
            sum   += int'(cnt[i]);
        end
        while (sum < int'(total_model))
        begin
            best = 0;
            for (int i = 1; i < LETTERS; i++)
                if (rem[i] > rem[best])
                    best = i;
            if (cnt[best] < COUNT_MAX)
                cnt[best]++;
            rem[best] = 0;
            sum++;
        end
        for (int i = 0; i < LETTERS; i++)
            pending_counts.push_back('{LETTER_W'(i), cnt[i], i == LETTERS - 1});
    endfunction

    task automatic send_item(input logic [FREQ_W-1:0] value, input bit typed,
                             input int exp_first, input int exp_rest);
        start <= 1'b1;
        freq  <= value;
        do @(posedge clk); while (busy);
        freq_mem[next_letter] = value;
        next_letter++;
        if (next_letter == LETTERS)
        begin
            next_letter = 0;
            if (typed)
            begin
                for (int i = 0; i < LETTERS; i++)
                    pending_counts.push_back('{LETTER_W'(i),
                        COUNT_W'(i == 0 ? exp_first : exp_rest), i == LETTERS - 1});
            end
            else
                predict_counts();
        end
    endtask

    task automatic idle_gap();
        int r;
        int n;

        r = $urandom_range(0, 9);
        n = (r < 5) ? 0 : (r < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // hold off until the block is idle, write total_count, then read it back
    task automatic write_total(input int value);
        start <= 1'b0;
        while (pending_counts.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TOTAL_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        total_model = COUNT_W'(value);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== APB_DATA_W'(total_model))
            report($sformatf("total_count read %0d, wrote %0d", prdata, total_model));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [FREQ_W-1:0] pattern_freq(input pattern_e pat, input int i);
        case (pat)
            PAT_ALT_BITS: return (i % 2 == 0) ? 23'h555555 : 23'h2AAAAA;
            PAT_ZERO:     return '0;
            PAT_MAX:      return FREQ_ONES;
            PAT_UNIFORM:  return FREQ_W'(FULL_SCALE / LETTERS);
            default:      return (i == 3) ? FREQ_W'(FULL_SCALE) : FREQ_W'(1000 + i * 7777);
        endcase
    endfunction

    function automatic logic [FREQ_W-1:0] random_freq(input mix_e mix);
        case (mix)
            MIX_WELL:   return FREQ_W'($urandom_range(0, 32'(2 * (FULL_SCALE / LETTERS))));
            MIX_SPARSE: return ($urandom_range(0, 4) == 0) ?
                               FREQ_W'($urandom_range(0, 32'(FULL_SCALE))) : '0;
            default:    return FREQ_W'($urandom);
        endcase
    endfunction

    function automatic int random_total();
        int r;

        r = $urandom_range(0, 7);
        if (r == 0)
            return 0;
        if (r == 1)
            return int'(COUNT_MAX);
        if (r == 2)
            return $urandom_range(1, 40);
        return $urandom_range(0, int'(COUNT_MAX));
    endfunction

    always @(posedge clk)
    begin
        letter_count_t want;

        if (rst_n && strobe)
        begin
            if (pending_counts.size() == 0)
                report($sformatf("unexpected count %0d for letter %0d", count, letter));
            else
            begin
                want = pending_counts.pop_front();
                if (letter !== want.letter)
                    report($sformatf("letter %0d, expected %0d", letter, want.letter));
                if (count !== want.count)
                    report($sformatf("letter %0d count %0d, expected %0d",
                                     want.letter, count, want.count));
                if (last !== want.last)
                    report($sformatf("letter %0d last %0b, expected %0b",
                                     want.letter, last, want.last));
            end
        end
    end

    initial
    begin
        int   mid;
        mix_e mix;
        int   r;

        mismatches  = 0;
        next_letter = 0;
        total_model = '0;
        rst_n   <= 1'b0;
        start   <= 1'b0;
        freq    <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (frame_table[f])
        begin
            if (frame_table[f].total != NO_WRITE)
                write_total(frame_table[f].total);
            for (int i = 0; i < LETTERS; i++)
            begin
                if (i == 13 && frame_table[f].mid_total != NO_WRITE)
                    write_total(frame_table[f].mid_total);
                send_item(pattern_freq(frame_table[f].pattern, i), frame_table[f].typed,
                          frame_table[f].exp_first, frame_table[f].exp_rest);
                idle_gap();
            end
        end

        for (int f = 0; f < RANDOM_FRAMES; f++)
        begin
            if ($urandom_range(0, 1) == 0)
                write_total(random_total());
            mid = ($urandom_range(0, 3) == 0) ? $urandom_range(1, LETTERS - 1) : NO_WRITE;
            r   = $urandom_range(0, 9);
            mix = (r < 6) ? MIX_WELL : (r < 8) ? MIX_SPARSE : MIX_NOISE;
            for (int i = 0; i < LETTERS; i++)
            begin
                if (i == mid)
                    write_total(random_total());
                send_item(random_freq(mix), 1'b0, 0, 0);
                idle_gap();
            end
        end

        start <= 1'b0;
        while (pending_counts.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
